>>> design/multi_list_stack_queue_engine_defines.svh
// assertion macros for the multi-list stack/queue engine
// no dependencies; included by the top level only
`ifndef MULTI_LIST_STACK_QUEUE_ENGINE_DEFINES_SVH
`define MULTI_LIST_STACK_QUEUE_ENGINE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MLSQ_ASSERT_NOW(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define MLSQ_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

>>> design/mlsq_pkg.sv
// shared constants and types for the multi-list stack/queue engine
// no dependencies
package mlsq_pkg;

    localparam int NUM_LISTS  = 16;
    localparam int POOL_DEPTH = 1024;
    localparam int DATA_WIDTH = 32;

    localparam int LIST_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int PTR_W  = $clog2(POOL_DEPTH);
    localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
    localparam int ID_W   = 4;
    localparam int VAL_W  = 32;

    typedef enum logic [1:0] {
        REQ_CREATE = 2'd0,
        REQ_PUSH   = 2'd1,
        REQ_POP    = 2'd2,
        REQ_NOP    = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EXISTS  = 3'd1,
        ST_MISSING = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

endpackage

>>> design/multi_list_stack_queue_engine.sv
// Multi-list stack/queue engine: up to NUM_LISTS lists, each a stack or a queue, share one
// linked pool of POOL_DEPTH nodes. In S_IDLE a request is accepted and the read of the link
// and data memories at the free-list head or the list head is issued; S_EXEC then does the
// update and writes back, and no new request is taken until it has done so.
// S_EXEC waits while a previous result has not yet been taken from the output
// register. Node links never written read as "next node", tracked by a fill count, so
// there is no clearing pass after reset. Every request gives exactly one result.
`include "multi_list_stack_queue_engine_defines.svh"

module multi_list_stack_queue_engine
    import mlsq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_req_type,
    input  logic [ID_W-1:0]  i_list_id,
    input  logic             i_list_kind,
    input  logic [VAL_W-1:0] i_push_value,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [2:0]       o_status,
    output logic [VAL_W-1:0] o_pop_value,
    output logic             o_pop_valid
);

    // control state
    t_state               r_state, n_state;
    logic [NUM_LISTS-1:0] r_created, n_created;
    logic [NUM_LISTS-1:0] r_is_queue, n_is_queue;
    logic [NUM_LISTS-1:0] r_nonempty, n_nonempty;
    logic [PTR_W-1:0]     r_free_head, n_free_head;
    logic [CNT_W-1:0]     r_free_cnt, n_free_cnt;
    logic [CNT_W-1:0]     r_fill, n_fill;
    logic                 r_out_valid, n_out_valid;

    // payload state
    logic [PTR_W-1:0]     r_head [NUM_LISTS];
    logic [PTR_W-1:0]     n_head [NUM_LISTS];
    logic [PTR_W-1:0]     r_tail [NUM_LISTS];
    logic [PTR_W-1:0]     n_tail [NUM_LISTS];
    t_req                 r_req, n_req;
    logic [LIST_W-1:0]    r_li, n_li;
    logic                 r_id_ok, n_id_ok;
    logic                 r_kind, n_kind;
    logic [VAL_W-1:0]     r_word, n_word;
    t_status              r_status, n_status;
    logic [VAL_W-1:0]     r_pop_value, n_pop_value;
    logic                 r_pop_valid, n_pop_valid;

    // memory ports
    logic                  link_we, link_re, data_we, data_re;
    logic [PTR_W-1:0]      link_waddr, link_wdata, link_raddr, link_rdata;
    logic [PTR_W-1:0]      data_waddr, data_raddr;
    logic [DATA_WIDTH-1:0] data_wdata, data_rdata;

    logic [LIST_W-1:0] in_li;
    logic [PTR_W-1:0]  node_n, next_free, head_cur;
    logic              fresh;
    logic              known;

    assign in_li    = LIST_W'(i_list_id);
    assign node_n   = r_free_head;
    assign head_cur = r_head[r_li];
    assign known    = r_id_ok && r_created[r_li];
    // a node at or above the fill mark was never handed out, its link is the next node
    assign fresh    = (CNT_W'(node_n) >= r_fill);
    assign next_free = fresh ? ((node_n == PTR_W'(POOL_DEPTH - 1)) ? '0 : node_n + PTR_W'(1))
                             : link_rdata;

    always_comb begin
        n_state     = r_state;
        n_created   = r_created;
        n_is_queue  = r_is_queue;
        n_nonempty  = r_nonempty;
        n_free_head = r_free_head;
        n_free_cnt  = r_free_cnt;
        n_fill      = r_fill;
        n_out_valid = r_out_valid;
        n_head      = r_head;
        n_tail      = r_tail;
        n_req       = r_req;
        n_li        = r_li;
        n_id_ok     = r_id_ok;
        n_kind      = r_kind;
        n_word      = r_word;
        n_status    = r_status;
        n_pop_value = r_pop_value;
        n_pop_valid = r_pop_valid;
        o_ready     = 1'b0;
        link_re     = 1'b0;
        data_re     = 1'b0;
        link_raddr  = r_head[in_li];
        data_raddr  = r_head[in_li];
        link_we     = 1'b0;
        link_waddr  = node_n;
        link_wdata  = head_cur;
        data_we     = 1'b0;
        data_waddr  = node_n;
        data_wdata  = DATA_WIDTH'(r_word);

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_req   = t_req'(i_req_type);
                    n_li    = in_li;
                    n_id_ok = (int'(i_list_id) < NUM_LISTS);
                    n_kind  = i_list_kind;
                    n_word  = i_push_value;
                    link_re = 1'b1;
                    data_re = 1'b1;
                    if (t_req'(i_req_type) == REQ_PUSH) begin
                        link_raddr = r_free_head;
                    end
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_out_valid || i_ready) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_pop_value = '0;
                    n_pop_valid = 1'b0;
                    case (r_req)
                        REQ_CREATE: begin
                            if (!r_id_ok) begin
                                n_status = ST_MISSING;
                            end else if (r_created[r_li]) begin
                                n_status = ST_EXISTS;
                            end else begin
                                n_created[r_li]  = 1'b1;
                                n_is_queue[r_li] = r_kind;
                                n_nonempty[r_li] = 1'b0;
                            end
                        end
                        REQ_PUSH: begin
                            if (!known) begin
                                n_status = ST_MISSING;
                            end else if (r_free_cnt == '0) begin
                                n_status = ST_FULL;
                            end else begin
                                n_free_head = next_free;
                                n_free_cnt  = r_free_cnt - CNT_W'(1);
                                if (fresh) begin
                                    n_fill = r_fill + CNT_W'(1);
                                end
                                data_we = 1'b1;
                                if (!r_nonempty[r_li]) begin
                                    n_head[r_li]     = node_n;
                                    n_tail[r_li]     = node_n;
                                    n_nonempty[r_li] = 1'b1;
                                end else if (r_is_queue[r_li]) begin
                                    // append behind the current tail
                                    link_we      = 1'b1;
                                    link_waddr   = r_tail[r_li];
                                    link_wdata   = node_n;
                                    n_tail[r_li] = node_n;
                                end else begin
                                    link_we      = 1'b1;
                                    link_waddr   = node_n;
                                    link_wdata   = head_cur;
                                    n_head[r_li] = node_n;
                                end
                            end
                        end
                        REQ_POP: begin
                            if (!known) begin
                                n_status = ST_MISSING;
                            end else if (!r_nonempty[r_li]) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_pop_value = VAL_W'(data_rdata);
                                n_pop_valid = 1'b1;
                                if (head_cur == r_tail[r_li]) begin
                                    n_nonempty[r_li] = 1'b0;
                                end else begin
                                    n_head[r_li] = link_rdata;
                                end
                                // freed node goes on top of the free list
                                link_we     = 1'b1;
                                link_waddr  = head_cur;
                                link_wdata  = r_free_head;
                                n_free_head = head_cur;
                                n_free_cnt  = r_free_cnt + CNT_W'(1);
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_created   <= '0;
            r_is_queue  <= '0;
            r_nonempty  <= '0;
            r_free_head <= '0;
            r_free_cnt  <= CNT_W'(POOL_DEPTH);
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_created   <= n_created;
            r_is_queue  <= n_is_queue;
            r_nonempty  <= n_nonempty;
            r_free_head <= n_free_head;
            r_free_cnt  <= n_free_cnt;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head      <= n_head;
        r_tail      <= n_tail;
        r_req       <= n_req;
        r_li        <= n_li;
        r_id_ok     <= n_id_ok;
        r_kind      <= n_kind;
        r_word      <= n_word;
        r_status    <= n_status;
        r_pop_value <= n_pop_value;
        r_pop_valid <= n_pop_valid;
    end

    mlsq_ram #(
        .WIDTH (PTR_W),
        .DEPTH (POOL_DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    mlsq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (POOL_DEPTH)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (data_waddr),
        .i_wdata (data_wdata),
        .i_re    (data_re),
        .i_raddr (data_raddr),
        .o_rdata (data_rdata)
    );

    assign o_valid     = r_out_valid;
    assign o_status    = r_status;
    assign o_pop_value = r_pop_value;
    assign o_pop_valid = r_pop_valid;

    `MLSQ_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_free_cnt <= CNT_W'(POOL_DEPTH), "free count above pool depth")
    `MLSQ_ASSERT_NOW(a_fresh_free, i_clk, i_rst_n, 1'b1, (int'(r_free_cnt) + int'(r_fill)) >= POOL_DEPTH, "untouched nodes not all free")
    `MLSQ_ASSERT_NEXT(a_fill_grows, i_clk, i_rst_n, 1'b1, r_fill >= $past(r_fill), "fill mark went backward")
    `MLSQ_ASSERT_NOW(a_pop_ok, i_clk, i_rst_n, o_valid && o_pop_valid, o_status == ST_OK, "popped word with error status")

endmodule

>>> design/mlsq_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module mlsq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> tb/sv/multi_list_stack_queue_engine_tb.sv
// self-checking testbench for the multi-list stack/queue engine: directed table then random
// traffic, every result checked against the table's expected value or a cycle-free model of the lists and the node pool
// depends on mlsq_pkg and the multi_list_stack_queue_engine top level
module multi_list_stack_queue_engine_tb
    import mlsq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 16;

    typedef struct {
        t_status          status;
        logic [VAL_W-1:0] pop_value;
        logic             pop_valid;
    } t_engine_result;

    typedef struct {
        t_req             kind;
        logic [ID_W-1:0]  id;
        logic             as_queue;
        logic [VAL_W-1:0] word;
        bit               typed;
        t_status          status;
        logic [VAL_W-1:0] pop_value;
        logic             pop_valid;
    } t_stim_row;

    localparam t_engine_result NO_OVERRIDE = '{ST_OK, 32'h0, 1'b0};

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_valid      = 1'b0;
    logic             o_ready;
    logic [1:0]       i_req_type   = 2'd0;
    logic [ID_W-1:0]  i_list_id    = '0;
    logic             i_list_kind  = 1'b0;
    logic [VAL_W-1:0] i_push_value = '0;
    logic             o_valid;
    logic             i_ready      = 1'b0;
    logic [2:0]       o_status;
    logic [VAL_W-1:0] o_pop_value;
    logic             o_pop_valid;

    multi_list_stack_queue_engine dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_list_id    (i_list_id),
        .i_list_kind  (i_list_kind),
        .i_push_value (i_push_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_pop_value  (o_pop_value),
        .o_pop_valid  (o_pop_valid)
    );

    // model of the engine state
    bit               list_made   [NUM_LISTS];
    bit               list_fifo   [NUM_LISTS];
    bit               list_filled [NUM_LISTS];
    logic [PTR_W-1:0] list_head   [NUM_LISTS];
    logic [PTR_W-1:0] list_tail   [NUM_LISTS];
    logic [VAL_W-1:0] node_word   [POOL_DEPTH];
    logic [PTR_W-1:0] node_next   [POOL_DEPTH];
    logic [PTR_W-1:0] free_first;
    logic [CNT_W-1:0] free_nodes;

    t_engine_result pending_results[$];
    int             err_cnt  = 0;
    bit             calm     = 1'b0;
    bit             hold_req = 1'b0;

    // directed table: extremes, every request kind and the MISSING, EXISTS and EMPTY statuses
    t_stim_row directed_rows [24] = '{
        '{REQ_POP,    4'd0,  1'b0, 32'h0000_0000, 1'b1, ST_MISSING, 32'h0, 1'b0},
        '{REQ_PUSH,   4'd15, 1'b1, 32'hFFFF_FFFF, 1'b1, ST_MISSING, 32'h0, 1'b0},
        '{REQ_NOP,    4'd5,  1'b0, 32'h0000_0000, 1'b1, ST_OK,      32'h0, 1'b0},
        '{REQ_CREATE, 4'd0,  1'b0, 32'h0000_0000, 1'b1, ST_OK,      32'h0, 1'b0},
        '{REQ_CREATE, 4'd0,  1'b1, 32'h0000_0000, 1'b1, ST_EXISTS,  32'h0, 1'b0},
        '{REQ_POP,    4'd0,  1'b0, 32'h0000_0000, 1'b1, ST_EMPTY,   32'h0, 1'b0},
        '{REQ_CREATE, 4'd15, 1'b1, 32'hFFFF_FFFF, 1'b1, ST_OK,      32'h0, 1'b0},
        '{REQ_PUSH,   4'd0,  1'b0, 32'h0000_0000, 1'b1, ST_OK,      32'h0, 1'b0},
        '{REQ_PUSH,   4'd0,  1'b1, 32'hFFFF_FFFF, 1'b1, ST_OK,      32'h0, 1'b0},
        '{REQ_PUSH,   4'd0,  1'b0, 32'h1234_5678, 1'b1, ST_OK,      32'h0, 1'b0},
        '{REQ_POP,    4'd0,  1'b0, 32'h0000_0000, 1'b0, ST_OK,      32'h0, 1'b0},
        '{REQ_POP,    4'd0,  1'b1, 32'hFFFF_FFFF, 1'b0, ST_OK,      32'h0, 1'b0},
        '{REQ_PUSH,   4'd15, 1'b0, 32'hA5A5_A5A5, 1'b1, ST_OK,      32'h0, 1'b0},
        '{REQ_PUSH,   4'd15, 1'b1, 32'h5A5A_5A5A, 1'b1, ST_OK,      32'h0, 1'b0},
        '{REQ_PUSH,   4'd15, 1'b0, 32'hFFFF_FFFF, 1'b1, ST_OK,      32'h0, 1'b0},
        '{REQ_POP,    4'd15, 1'b0, 32'h0000_0000, 1'b0, ST_OK,      32'h0, 1'b0},
        '{REQ_POP,    4'd15, 1'b0, 32'h0000_0000, 1'b0, ST_OK,      32'h0, 1'b0},
        '{REQ_POP,    4'd0,  1'b0, 32'h0000_0000, 1'b0, ST_OK,      32'h0, 1'b0},
        '{REQ_POP,    4'd0,  1'b0, 32'h0000_0000, 1'b1, ST_EMPTY,   32'h0, 1'b0},
        '{REQ_POP,    4'd15, 1'b0, 32'h0000_0000, 1'b0, ST_OK,      32'h0, 1'b0},
        '{REQ_POP,    4'd15, 1'b0, 32'h0000_0000, 1'b1, ST_EMPTY,   32'h0, 1'b0},
        '{REQ_NOP,    4'd15, 1'b1, 32'hFFFF_FFFF, 1'b1, ST_OK,      32'h0, 1'b0},
        '{REQ_CREATE, 4'd15, 1'b0, 32'h0000_0000, 1'b1, ST_EXISTS,  32'h0, 1'b0},
        '{REQ_PUSH,   4'd7,  1'b1, 32'h8000_0001, 1'b1, ST_MISSING, 32'h0, 1'b0}
    };

    // applies one request to the model state and returns its result
    function automatic t_engine_result engine_apply(input t_req kind, input logic [ID_W-1:0] id,
                                                    input logic as_queue,
                                                    input logic [VAL_W-1:0] word);
        t_engine_result   res;
        logic [PTR_W-1:0] node;
        bit               known;
        res   = NO_OVERRIDE;
        known = (int'(id) < NUM_LISTS) && list_made[id];
        case (kind)
            REQ_CREATE: begin
                if (int'(id) >= NUM_LISTS) begin
                    res.status = ST_MISSING;
                end else if (list_made[id]) begin
                    res.status = ST_EXISTS;
                end else begin
                    list_made[id]   = 1'b1;
                    list_fifo[id]   = as_queue;
                    list_filled[id] = 1'b0;
                end
            end
            REQ_PUSH: begin
                if (!known) begin
                    res.status = ST_MISSING;
                end else if (free_nodes == 0) begin
                    res.status = ST_FULL;
                end else begin
                    node            = free_first;
                    free_first      = node_next[node];
                    free_nodes      = free_nodes - 1'b1;
                    node_word[node] = word;
                    if (!list_filled[id]) begin
                        list_head[id]   = node;
                        list_tail[id]   = node;
                        list_filled[id] = 1'b1;
                    end else if (list_fifo[id]) begin
                        node_next[list_tail[id]] = node;
                        list_tail[id]            = node;
                    end else begin
                        node_next[node] = list_head[id];
                        list_head[id]   = node;
                    end
                end
            end
            REQ_POP: begin
                if (!known) begin
                    res.status = ST_MISSING;
                end else if (!list_filled[id]) begin
                    res.status = ST_EMPTY;
                end else begin
                    node          = list_head[id];
                    res.pop_value = node_word[node];
                    res.pop_valid = 1'b1;
                    // last node out leaves the list empty, head is left stale
                    if (node == list_tail[id])
                        list_filled[id] = 1'b0;
                    else
                        list_head[id] = node_next[node];
                    node_next[node] = free_first;
                    free_first      = node;
                    free_nodes      = free_nodes + 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [VAL_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // one input transfer, with an optional idle burst in front of it
    task automatic offer_request(input t_req kind, input logic [ID_W-1:0] id,
                                 input logic as_queue, input logic [VAL_W-1:0] word,
                                 input bit typed, input t_engine_result typed_res);
        t_engine_result pred;
        int             gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= kind;
        i_list_id    <= id;
        i_list_kind  <= as_queue;
        i_push_value <= word;
        do @(posedge i_clk); while (!o_ready);
        pred = engine_apply(kind, id, as_queue, word);
        if (typed)
            pred = typed_res;
        pending_results.insert(pending_results.size(), pred);
    endtask

    task automatic random_request(input int create_pct, input int nop_pct, input int pop_pct);
        int   pick;
        t_req kind;
        pick = $urandom_range(0, 99);
        if (pick < create_pct)
            kind = REQ_CREATE;
        else if (pick < create_pct + nop_pct)
            kind = REQ_NOP;
        else if (pick < create_pct + nop_pct + pop_pct)
            kind = REQ_POP;
        else
            kind = REQ_PUSH;
        offer_request(kind, ID_W'($urandom_range(0, NUM_LISTS - 1)), 1'($urandom_range(0, 1)),
                      rand_word(), 1'b0, NO_OVERRIDE);
    endtask

    // sender stops until every outstanding result has been taken
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("multi_list_stack_queue_engine_tb: errors");
        $finish;
    end

    // result side: random stall bursts plus one long hold on request
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0)
                stall_left--;
            else if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD;
            end else if (!calm && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 17);
            i_ready <= i_rst_n && (stall_left == 0);
        end
    end

    always @(posedge i_clk) begin : check_result
        t_engine_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing outstanding: status %0d", o_status);
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    err_cnt++;
                end
                if (o_pop_value !== want.pop_value) begin
                    $error("pop_value: expected %08h, got %08h", want.pop_value, o_pop_value);
                    err_cnt++;
                end
                if (o_pop_valid !== want.pop_valid) begin
                    $error("pop_valid: expected %0b, got %0b", want.pop_valid, o_pop_valid);
                    err_cnt++;
                end
            end
        end
    end

    initial begin : stimulus
        t_engine_result row_res;
        int             waited;
        for (int k = 0; k < NUM_LISTS; k++) begin
            list_made[k]   = 1'b0;
            list_fifo[k]   = 1'b0;
            list_filled[k] = 1'b0;
            list_head[k]   = '0;
            list_tail[k]   = '0;
        end
        for (int k = 0; k < POOL_DEPTH; k++) begin
            node_word[k] = '0;
            node_next[k] = PTR_W'(k + 1);
        end
        free_first = '0;
        free_nodes = CNT_W'(POOL_DEPTH);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            row_res = '{directed_rows[k].status, directed_rows[k].pop_value,
                        directed_rows[k].pop_valid};
            offer_request(directed_rows[k].kind, directed_rows[k].id, directed_rows[k].as_queue,
                          directed_rows[k].word, directed_rows[k].typed, row_res);
        end

        // mixed traffic across all lists; the long output hold backs the engine up
        for (int k = 0; k < 120; k++) begin
            if (k == 40)
                hold_req = 1'b1;
            random_request(12, 4, 35);
        end
        wait_results_drained();

        // make sure every list exists, then fill the pool and push against it
        for (int k = 0; k < NUM_LISTS; k++)
            offer_request(REQ_CREATE, ID_W'(k), 1'($urandom_range(0, 1)), rand_word(),
                          1'b0, NO_OVERRIDE);
        while (free_nodes != 0)
            random_request(0, 0, 2);
        repeat (25) random_request(0, 2, 30);
        wait_results_drained();

        // closing stretch without idling on either side
        calm = 1'b1;
        repeat (80) random_request(5, 4, 60);

        i_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            err_cnt++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("multi_list_stack_queue_engine_tb: clean");
        else
            $display("multi_list_stack_queue_engine_tb: errors");
        $finish;
    end

endmodule
